>>> src/dcr_pkg.sv
package dcr_pkg;

  typedef enum logic [1:0] {
    ST_BYTE   = 2'd0,
    ST_FINAL  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data;
    status_e    status;
    logic       last;
  } result_t;

  localparam int unsigned HeaderLen  = 12;
  localparam int unsigned AnswerLen  = 16;
  localparam int unsigned MaxLabel   = 63;
  localparam int unsigned TailLen    = 4;

  // Header rewrite: flags 0x8180, ANCOUNT 1, NSCOUNT and ARCOUNT 0.
  function automatic logic [7:0] header_byte(input logic [3:0] pos, input logic [7:0] b);
    logic [7:0] r;
    r = b;
    case (pos)
      4'd2:  r = 8'h81;
      4'd3:  r = 8'h80;
      4'd6:  r = 8'h00;
      4'd7:  r = 8'h01;
      4'd8, 4'd9, 4'd10, 4'd11: r = 8'h00;
      default: r = b;
    endcase
    return r;
  endfunction

  // A record: pointer to the question name, type A, class IN, TTL 60, length 4, address.
  function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
    logic [7:0] r;
    r = 8'h00;
    case (idx)
      4'd0:  r = 8'hC0;
      4'd1:  r = 8'h0C;
      4'd2:  r = 8'h00;
      4'd3:  r = 8'h01;
      4'd4:  r = 8'h00;
      4'd5:  r = 8'h01;
      4'd6:  r = 8'h00;
      4'd7:  r = 8'h00;
      4'd8:  r = 8'h00;
      4'd9:  r = 8'h3C;
      4'd10: r = 8'h00;
      4'd11: r = 8'h04;
      4'd12: r = addr[31:24];
      4'd13: r = addr[23:16];
      4'd14: r = addr[15:8];
      4'd15: r = addr[7:0];
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

>>> src/dcr_skid.sv
module dcr_skid
  import dcr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    up_valid_i,
  output logic    up_ready_o,
  input  result_t up_data_i,
  output logic    dn_valid_o,
  input  logic    dn_ready_i,
  output result_t dn_data_o
);

  logic    out_valid_q;
  result_t out_data_q;
  logic    skid_valid_q;
  result_t skid_data_q;

  assign up_ready_o = !skid_valid_q;
  assign dn_valid_o = out_valid_q;
  assign dn_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (dn_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        // drain the skid entry first to keep order
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= up_valid_i;
      end
    end else if (up_valid_i && up_ready_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dn_ready_i || !out_valid_q) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (up_valid_i) begin
        out_data_q <= up_data_i;
      end
    end else if (up_valid_i && up_ready_o) begin
      skid_data_q <= up_data_i;
    end
  end

endmodule

>>> src/dns_captive_responder_top.sv
// DNS captive-portal responder.
// Input channel: one query byte per item (in_byte_i, in_last_i marks the
// datagram's final byte), valid/ready. Output channel: one reply byte per
// item with reply_status_o (byte, final byte, reject) and out_last_o.
// Config: cfg_we_i writes cfg_wdata_i as the portal IPv4 address.
// Each query byte is parsed in the cycle it is accepted and its result is
// registered. Throughput is one byte per cycle while in_ready_o is high.
// The fourth QTYPE/QCLASS byte also starts a 16-byte answer sequencer;
// in_ready_o stays low while it emits. A reject result replaces the
// partial reply; the remaining bytes of that frame are taken and give
// no result.
// The output side is a two-entry buffer (output register plus skid entry):
// input is still taken while one finished result waits, and in_ready_o
// drops once both entries are full, and while the answer is emitted.
// Reset clears the parser to the start of a frame, empties the buffer and
// sets the portal address to zero.
module dns_captive_responder_top
  import dcr_pkg::*;
#(
  parameter int unsigned MAX_QUERY    = 512,
  parameter int unsigned MAX_RESPONSE = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  reply_status_o,
  output logic        out_last_o
);

  localparam int unsigned PosW = $clog2(MAX_QUERY);
  localparam int unsigned CmpW = $clog2(MAX_QUERY + MAX_RESPONSE) + 1;
  localparam int unsigned LastAns = AnswerLen - 1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LABEL_LEN,
    PH_LABEL_BODY,
    PH_TAIL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [5:0]  rem_q, rem_d;
  logic [1:0]  tail_q, tail_d;
  logic        fin_q, fin_d;
  logic        ans_busy_q, ans_busy_d;
  logic [3:0]  ans_idx_q, ans_idx_d;
  logic [31:0] addr_q;

  logic    sk_ready;
  logic    emit;
  result_t res;
  result_t dn_data;
  logic    in_acc;
  logic    eff_last;
  logic    over_size;
  logic    rej;
  logic    done;

  assign in_ready_o = sk_ready && !ans_busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign eff_last   = in_last_i || (pos_q == PosW'(MAX_QUERY - 1));
  assign over_size  = CmpW'(pos_q) + CmpW'(17) > CmpW'(MAX_RESPONSE);

  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    rem_d      = rem_q;
    tail_d     = tail_q;
    fin_d      = fin_q;
    ans_busy_d = ans_busy_q;
    ans_idx_d  = ans_idx_q;
    emit       = 1'b0;
    rej        = 1'b0;
    done       = 1'b0;
    res        = '{data: 8'h00, status: ST_BYTE, last: 1'b0};

    if (ans_busy_q) begin
      if (sk_ready) begin
        emit     = 1'b1;
        res.data = answer_byte(ans_idx_q, addr_q);
        if (ans_idx_q == 4'(LastAns)) begin
          res.status = ST_FINAL;
          res.last   = 1'b1;
          ans_busy_d = 1'b0;
        end
        ans_idx_d = ans_idx_q + 4'd1;
      end
    end else if (in_acc) begin
      if (fin_q) begin
        // drop the rest of the frame
        if (in_last_i) begin
          fin_d   = 1'b0;
          pos_d   = '0;
          phase_d = PH_HEADER;
          rem_d   = '0;
          tail_d  = '0;
        end
      end else begin
        if (over_size) begin
          rej = 1'b1;
        end else begin
          unique case (phase_q)
            PH_HEADER: begin
              emit     = 1'b1;
              res.data = header_byte(pos_q[3:0], in_byte_i);
              if (pos_q >= PosW'(HeaderLen - 1)) phase_d = PH_LABEL_LEN;
            end
            PH_LABEL_LEN: begin
              // lengths above 63 include compression pointers
              if (in_byte_i > 8'(MaxLabel)) begin
                rej = 1'b1;
              end else begin
                emit     = 1'b1;
                res.data = in_byte_i;
                if (in_byte_i == 8'h00) begin
                  phase_d = PH_TAIL;
                  tail_d  = '0;
                end else begin
                  rem_d   = in_byte_i[5:0];
                  phase_d = PH_LABEL_BODY;
                end
              end
            end
            PH_LABEL_BODY: begin
              emit     = 1'b1;
              res.data = in_byte_i;
              rem_d    = rem_q - 6'd1;
              if (rem_q == 6'd1) phase_d = PH_LABEL_LEN;
            end
            PH_TAIL: begin
              emit     = 1'b1;
              res.data = in_byte_i;
              if (tail_q == 2'(TailLen - 1)) begin
                done       = 1'b1;
                ans_busy_d = 1'b1;
                ans_idx_d  = '0;
              end else begin
                tail_d = tail_q + 2'd1;
              end
            end
            default: ;
          endcase
        end

        if (!done && !rej && eff_last) rej = 1'b1;

        if (rej) begin
          emit       = 1'b1;
          res        = '{data: 8'h00, status: ST_REJECT, last: 1'b1};
          done       = 1'b1;
          ans_busy_d = 1'b0;
        end

        if (done) begin
          if (in_last_i) begin
            fin_d   = 1'b0;
            pos_d   = '0;
            phase_d = PH_HEADER;
            rem_d   = '0;
            tail_d  = '0;
          end else begin
            fin_d = 1'b1;
          end
        end else begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HEADER;
      pos_q      <= '0;
      rem_q      <= '0;
      tail_q     <= '0;
      fin_q      <= 1'b0;
      ans_busy_q <= 1'b0;
      ans_idx_q  <= '0;
      addr_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      tail_q     <= tail_d;
      fin_q      <= fin_d;
      ans_busy_q <= ans_busy_d;
      ans_idx_q  <= ans_idx_d;
      if (cfg_we_i) addr_q <= cfg_wdata_i;
    end
  end

  dcr_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (emit),
    .up_ready_o (sk_ready),
    .up_data_i  (res),
    .dn_valid_o (out_valid_o),
    .dn_ready_i (out_ready_i),
    .dn_data_o  (dn_data)
  );

  assign out_byte_o     = dn_data.data;
  assign reply_status_o = dn_data.status;
  assign out_last_o     = dn_data.last;

endmodule

>>> src/dcr_checker.sv
module dcr_checker
  import dcr_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic [1:0] reply_status_o,
  input logic       out_last_o
);

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (reply_status_o == ST_BYTE || reply_status_o == ST_FINAL ||
                     reply_status_o == ST_REJECT))
    else $error("illegal reply status");

  a_reject_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_status_o == ST_REJECT) |-> (out_byte_o == 8'h00 && out_last_o))
    else $error("reject item must carry zero byte and last");

  a_last_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_last_o == (reply_status_o != ST_BYTE)))
    else $error("last flag disagrees with status");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(reply_status_o) && $stable(out_last_o)))
    else $error("stalled output item changed");

endmodule

bind dns_captive_responder_top dcr_checker u_dcr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .out_byte_o     (out_byte_o),
  .reply_status_o (reply_status_o),
  .out_last_o     (out_last_o)
);
